[hdl/bsbc_pkg.sv]
// shared types and constants for the bracket shift balance checker
`default_nettype none

package bsbc_pkg;

   localparam logic [7:0] CHAR_OPEN    = 8'h5B;  // [
   localparam logic [7:0] CHAR_CLOSE   = 8'h5D;  // ]
   localparam logic [7:0] CHAR_RIGHT   = 8'h3E;  // >
   localparam logic [7:0] CHAR_LEFT    = 8'h3C;  // <
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [23:0]        U24_MAX   = 24'hFFFFFF;
   localparam logic signed [23:0] SHIFT_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] SHIFT_MIN = 24'sh800000;

   typedef enum logic [1:0] {
      KIND_IMBALANCE = 2'd0,
      KIND_UNMATCHED = 2'd1,
      KIND_OVERFLOW  = 2'd2
   } report_kind_type;

   typedef struct packed {
      logic [23:0]        loop_number;
      logic [23:0]        line;
      logic signed [23:0] shift;
   } frame_type;

   typedef struct packed {
      report_kind_type    kind;
      logic [23:0]        loop_number;
      logic [23:0]        open_line;
      logic signed [23:0] shift_balance;
      logic [23:0]        current_line;
   } report_type;

endpackage

`default_nettype wire

[hdl/bsbc_frame_stack.sv]
// frame memory below the stack top, registered read with write bypass
`default_nettype none

module bsbc_frame_stack import bsbc_pkg::*; #(
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire frame_type         wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output frame_type              rd_data
);

   localparam int MEM_DEPTH = 1 << ADDR_W;

   frame_type mem [0:MEM_DEPTH-1];
   frame_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // same-address write forwards the new frame
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

[hdl/bracket_shift_balance_checker.sv]
// top level: bracket checker reporting loop shift imbalance, unmatched ], overflow
// an accepted item goes to the input register, its report to the result register
// throughput: one item per cycle; the stack top lives in registers and the frame
// below it is prefetched every cycle; input stalls only while a report waits
// reset: loop counter, stack pointer, halt flag and valids clear, the line counter
// goes to one; frame memory is not cleared (a frame is always written before use)
`default_nettype none

module bracket_shift_balance_checker import bsbc_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_report_kind,
   output logic [23:0]      rsp_loop_number,
   output logic [23:0]      rsp_open_line,
   output logic signed [23:0] rsp_shift_balance,
   output logic [23:0]      rsp_current_line
);

   localparam int SPW = $clog2(STACK_DEPTH + 1);
   localparam int AW  = $clog2(STACK_DEPTH);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_char_ff;

   // stack and counter state
   logic [SPW-1:0] sp_ff, sp_in;
   logic [23:0]    line_ff, line_in;
   logic [23:0]    loop_ff, loop_in;
   logic           halted_ff, halted_in;
   frame_type      top_ff, top_in;

   // result register
   logic       rsp_vld_ff, rsp_vld_in;
   report_type rep_ff, rep_new;
   logic       emit;

   // frame memory hookup
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic [SPW-1:0] sp_minus1;
   logic [SPW-1:0] sp_rd;
   frame_type      under_frame;

   logic out_free;
   logic fire;
   logic sp_empty;
   logic sp_full;

   // a stage moves when the result register is empty or draining
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign fire      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;

   assign sp_empty  = (sp_ff == '0);
   assign sp_full   = (sp_ff == SPW'(STACK_DEPTH));
   assign sp_minus1 = sp_ff - SPW'(1);

   // old top spills to memory at slot sp-1 on a push
   assign wr_addr = sp_minus1[AW-1:0];

   // keep the frame just below the next top prefetched
   assign sp_rd   = sp_in - SPW'(2);
   assign rd_addr = sp_rd[AW-1:0];

   // per-item decode and state update
   always_comb begin
      sp_in     = sp_ff;
      line_in   = line_ff;
      loop_in   = loop_ff;
      halted_in = halted_ff;
      top_in    = top_ff;
      wr_en     = 1'b0;
      emit      = 1'b0;
      rep_new   = '{kind: KIND_IMBALANCE, loop_number: '0, open_line: '0,
                    shift_balance: '0, current_line: line_ff};
      if (fire && !halted_ff) begin
         unique case (in_char_ff)
            CHAR_OPEN: begin
               if (sp_full) begin
                  halted_in    = 1'b1;
                  emit         = 1'b1;
                  rep_new.kind = KIND_OVERFLOW;
               end else begin
                  if (loop_ff != U24_MAX) begin
                     loop_in = loop_ff + 24'd1;
                  end
                  wr_en              = !sp_empty;
                  top_in.loop_number = loop_in;
                  top_in.line        = line_ff;
                  top_in.shift       = '0;
                  sp_in              = sp_ff + SPW'(1);
               end
            end
            CHAR_CLOSE: begin
               if (sp_empty) begin
                  halted_in    = 1'b1;
                  emit         = 1'b1;
                  rep_new.kind = KIND_UNMATCHED;
               end else begin
                  sp_in  = sp_minus1;
                  top_in = under_frame;
                  if (top_ff.shift != '0) begin
                     emit                  = 1'b1;
                     rep_new.loop_number   = top_ff.loop_number;
                     rep_new.open_line     = top_ff.line;
                     rep_new.shift_balance = top_ff.shift;
                  end
               end
            end
            CHAR_RIGHT: begin
               if (!sp_empty && (top_ff.shift != SHIFT_MAX)) begin
                  top_in.shift = top_ff.shift + 24'sd1;
               end
            end
            CHAR_LEFT: begin
               if (!sp_empty && (top_ff.shift != SHIFT_MIN)) begin
                  top_in.shift = top_ff.shift - 24'sd1;
               end
            end
            CHAR_NEWLINE: begin
               if (line_ff != U24_MAX) begin
                  line_in = line_ff + 24'd1;
               end
            end
            default: begin
               // any other byte leaves the state alone
            end
         endcase
      end
   end

   // input register takes a new item whenever it is empty or moving on
   always_comb begin
      in_vld_in = req_valid || (in_vld_ff && !fire);
   end

   // result valid holds while stalled, reloads only on a report
   always_comb begin
      if (emit) begin
         rsp_vld_in = 1'b1;
      end else begin
         rsp_vld_in = rsp_vld_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         sp_ff      <= '0;
         line_ff    <= 24'd1;
         loop_ff    <= '0;
         halted_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         sp_ff      <= sp_in;
         line_ff    <= line_in;
         loop_ff    <= loop_in;
         halted_ff  <= halted_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
      end
      if (emit) begin
         rep_ff <= rep_new;
      end
      top_ff <= top_in;
   end

   bsbc_frame_stack #(
      .ADDR_W (AW)
   ) u_frame_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (under_frame)
   );

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_report_kind   = rep_ff.kind;
   assign rsp_loop_number   = rep_ff.loop_number;
   assign rsp_open_line     = rep_ff.open_line;
   assign rsp_shift_balance = rep_ff.shift_balance;
   assign rsp_current_line  = rep_ff.current_line;

   // once halted, only reset releases the block
   assert property (@(posedge clock) disable iff (reset) halted_ff |=> halted_ff)
      else $error("halt flag dropped without reset");

   // stack pointer never runs past the depth
   assert property (@(posedge clock) disable iff (reset) sp_ff <= SPW'(STACK_DEPTH))
      else $error("stack pointer beyond depth");

   // an error report always comes with the halt flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rep_ff.kind != KIND_IMBALANCE)) |-> halted_ff)
      else $error("error report without halt");

   // items drained while halted leave the stack alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && halted_ff) |=> $stable(sp_ff))
      else $error("stack moved while halted");

   // line counter starts at one and never wraps
   assert property (@(posedge clock) disable iff (reset) line_ff != '0)
      else $error("line counter reached zero");

endmodule

`default_nettype wire
